// ===== rtl/pig_pkg.sv =====
package pig_pkg;

    // index arithmetic width, fixed by the state and field definitions
    localparam int IDX_W  = 32;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        TOPO_LIST       = 3'd0,
        TOPO_TRI_STRIP  = 3'd1,
        TOPO_LINE_STRIP = 3'd2,
        TOPO_FAN        = 3'd3,
        TOPO_STRIP_LIST = 3'd4
    } topo_mode_t;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_STRIDE = 2'd1;
    localparam logic [1:0] REG_WIDE   = 2'd2;

    localparam logic [2:0] RST_MODE   = 3'd0;
    localparam logic [7:0] RST_STRIDE = 8'd4;
    localparam logic       RST_WIDE   = 1'b1;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] stride;
        logic       wide;
    } cfg_t;

endpackage

// ===== rtl/pig_apb_regs.sv =====
module pig_apb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pig_pkg::ADDR_W-1:0]  paddr,
    input  logic [pig_pkg::DATA_W-1:0]  pwdata,
    output logic [pig_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output pig_pkg::cfg_t               cfg
);
    import pig_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= RST_MODE;
            cfg_reg.stride <= RST_STRIDE;
            cfg_reg.wide   <= RST_WIDE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:   cfg_reg.mode   <= pwdata[2:0];
                REG_STRIDE: cfg_reg.stride <= pwdata[7:0];
                REG_WIDE:   cfg_reg.wide   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:   prdata = {29'd0, cfg_reg.mode};
            REG_STRIDE: prdata = {24'd0, cfg_reg.stride};
            REG_WIDE:   prdata = {31'd0, cfg_reg.wide};
            default:    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pig_index_calc.sv =====
module pig_index_calc #(
    parameter int INDEX_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [pig_pkg::IDX_W-1:0]  start_index,
    input  logic                       new_sequence,
    input  pig_pkg::cfg_t              cfg,
    output logic [INDEX_BITS-1:0]      vertex_index
);
    import pig_pkg::*;

    // step count plus tracked values: c mod 3, c - 2*(c/3), phase, line position, strip base
    logic [IDX_W-1:0] count_reg, count_next;
    logic [1:0]       mod3_reg, mod3_next;
    logic [IDX_W-1:0] offset_reg, offset_next;
    logic [2:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] line_pos_reg, line_pos_next;
    logic [IDX_W-1:0] base_reg, base_next;

    logic [IDX_W-1:0] c, off, line_pos, base, c_inc, adj, result;
    logic [IDX_W-1:0] stride_m2, per_strip;
    logic [1:0]       m3;
    logic [2:0]       ph, ph_inc;
    logic [INDEX_BITS-1:0] mask;

    // a new sequence clears the state before this index is formed
    always_comb begin
        c        = new_sequence ? '0 : count_reg;
        m3       = new_sequence ? '0 : mod3_reg;
        off      = new_sequence ? '0 : offset_reg;
        ph       = new_sequence ? '0 : phase_reg;
        line_pos = new_sequence ? '0 : line_pos_reg;
        base     = new_sequence ? '0 : base_reg;
    end

    assign c_inc     = c + 32'd1;
    assign stride_m2 = {24'd0, cfg.stride} - 32'd2;
    assign per_strip = stride_m2 + {stride_m2[IDX_W-2:0], 1'b0};

    always_comb begin
        case (ph)
            3'd4:    adj = 32'd1;
            3'd5:    adj = '1;
            default: adj = '0;
        endcase
        ph_inc = (ph >= 3'd5) ? 3'd0 : ph + 3'd1;
    end

    always_comb begin
        count_next    = c_inc;
        line_pos_next = line_pos;
        base_next     = base;
        phase_next    = ph;
        // counter wrap restarts the mod-3 tracking, since 2^32 is not a multiple of 3
        if (c_inc == '0) begin
            mod3_next   = '0;
            offset_next = '0;
        end else if (m3 == 2'd2) begin
            mod3_next   = '0;
            offset_next = off - 32'd1;
        end else begin
            mod3_next   = m3 + 2'd1;
            offset_next = off + 32'd1;
        end
        case (cfg.mode)
            TOPO_TRI_STRIP: begin
                result     = start_index + off + adj;
                phase_next = ph_inc;
            end
            TOPO_LINE_STRIP: begin
                result = start_index + line_pos;
                if (!c[0]) begin
                    line_pos_next = line_pos + 32'd1;
                end
            end
            TOPO_FAN: begin
                result = (m3 == 2'd0) ? start_index : start_index + off;
            end
            TOPO_STRIP_LIST: begin
                result     = start_index + base + off + adj;
                phase_next = ph_inc;
                if (c_inc == per_strip) begin
                    base_next   = base + {24'd0, cfg.stride};
                    count_next  = '0;
                    mod3_next   = '0;
                    offset_next = '0;
                    phase_next  = '0;
                end
            end
            default: begin
                result = start_index + c;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            mod3_reg     <= '0;
            offset_reg   <= '0;
            phase_reg    <= '0;
            line_pos_reg <= '0;
            base_reg     <= '0;
        end else if (step) begin
            count_reg    <= count_next;
            mod3_reg     <= mod3_next;
            offset_reg   <= offset_next;
            phase_reg    <= phase_next;
            line_pos_reg <= line_pos_next;
            base_reg     <= base_next;
        end
    end

    assign mask         = cfg.wide ? '1 : INDEX_BITS'(32'h0000_FFFF);
    assign vertex_index = result[INDEX_BITS-1:0] & mask;

endmodule

// ===== rtl/primitive_index_generator.sv =====
// channel   | dir | payload                                   | handshake
// s_ (req)  | in  | tdata: start_index; tuser: new_sequence   | tvalid/tready
// m_ (idx)  | out | tdata: vertex_index                       | tvalid/tready
// apb cfg   | in  | topology_mode, vertex_stride, wide_indices| psel/penable
//
// one index per clock sustained while m_tready stays high; an s_ transfer reaches m_tvalid
// through the input register, then the index adders and the result register
// aresetn synchronous: clears counters, phase, line position, base, config and valid flags
// an m_ stall holds the result; the input register still takes one more item while it is empty
module primitive_index_generator #(
    parameter int INDEX_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] start_index
    input  logic [0:0]                  s_tuser,   // [0] new_sequence
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] vertex_index
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pig_pkg::ADDR_W-1:0]  paddr,
    input  logic [pig_pkg::DATA_W-1:0]  pwdata,
    output logic [pig_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import pig_pkg::*;

    cfg_t cfg;

    logic                  in_valid_reg;
    logic [IDX_W-1:0]      in_start_reg;
    logic                  in_newseq_reg;
    logic                  out_valid_reg;
    logic [INDEX_BITS-1:0] out_index_reg;
    logic [INDEX_BITS-1:0] calc_index;
    logic                  advance;
    logic                  step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    pig_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pig_index_calc #(
        .INDEX_BITS (INDEX_BITS)
    ) u_calc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .start_index  (in_start_reg),
        .new_sequence (in_newseq_reg),
        .cfg          (cfg),
        .vertex_index (calc_index)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_start_reg  <= s_tdata;
            in_newseq_reg <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_index_reg <= calc_index;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 32'(out_index_reg);

endmodule

// ===== rtl/pig_checker.sv =====
module pig_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [31:0]                 m_tdata,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [pig_pkg::ADDR_W-1:0]  paddr,
    input logic [pig_pkg::DATA_W-1:0]  pwdata,
    input logic                        pready
);
    import pig_pkg::*;

    // copy of the index-width register as seen on the config port
    logic wide_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_reg <= RST_WIDE;
        end else if (psel && penable && pwrite && pready && paddr[3:2] == REG_WIDE) begin
            wide_reg <= pwdata[0];
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty result register");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted request produced no result in time");

    a_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !wide_reg |-> m_tdata[31:16] == 16'd0)
        else $error("upper index bits set in narrow mode");

endmodule

bind primitive_index_generator pig_checker u_pig_checker (.*);
